### design/cgcs_pkg.sv
// ----------------------------------------------------------------------------
// cgcs_pkg
// shared types, codes and the exp2 root table for the gain computer/smoother
// ----------------------------------------------------------------------------
package cgcs_pkg;

    typedef enum logic [2:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_RATIO     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_MAKEUP    = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_LOG_INIT_L,
        OP_LOG_STEP,
        OP_LOG_INIT_T,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MUL_P,
        OP_EXP_A,
        OP_EXP_B,
        OP_TARGET,
        OP_SMOOTH,
        OP_OUT_T,
        OP_OUT_U
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOG_L,
        ST_LOG_T_INIT,
        ST_LOG_T,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL_P,
        ST_EXP_A,
        ST_EXP_B,
        ST_TARGET,
        ST_SMOOTH,
        ST_OUT_T,
        ST_OUT_U
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic above;
        logic out_free;
    } status_t;

    localparam int LOG_STEPS = 16;
    localparam int DIV_STEPS = 25;
    localparam int EXP_STEPS = 16;

    localparam logic [16:0] UNITY_GAIN = 17'h10000;

    typedef logic [29:0] exp_tbl_t [17];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] r;
        logic [63:0] b;
        rem = v;
        r   = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r   = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry k is 2^-(2^-k) in Q0.30 built by repeated floor square roots
    function automatic exp_tbl_t build_exp_tbl();
        exp_tbl_t    t;
        logic [63:0] s;
        t[0] = 30'h20000000;
        for (int k = 1; k <= 16; k++)
        begin
            s    = isqrt64({4'd0, t[k-1], 30'd0});
            t[k] = s[29:0];
        end
        return t;
    endfunction

endpackage

### design/compressor_gain_computer_smoother_top.sv
// ----------------------------------------------------------------------------
// compressor_gain_computer_smoother_top
// feedforward compressor gain computer with attack/release gain smoothing
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one sample with its detected level per transfer;
//   master stream returns the compressed sample and the gain applied.
//   the config port writes threshold, ratio, attack, release and makeup
//   gain by index; writing only while the block is idle is up to the user.
// timing:
//   one item at a time. below the threshold the item goes from the check
//   state straight to the smoothing and output multiply states; above it
//   the log2 units (16 squaring steps each, level then threshold), the
//   25-step ratio divider and the 16 exp2 multiply steps, each an A and
//   then a B state, come first.
//   s_tready is high only while the sequencer waits for an item.
// reset:
//   config registers return to their defaults and the kept gain to unity.
// stall:
//   the result waits in the output register; a new item may be taken and
//   worked on meanwhile, holding only at the final step until it is free.
// ----------------------------------------------------------------------------
module compressor_gain_computer_smoother_top #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sample_in, level_in
    input  logic [((SAMPLE_BITS+24+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sample_out, gain_now
    output logic [((SAMPLE_BITS+17+7)/8)*8-1:0] m_tdata
);

    localparam int OW = ((SAMPLE_BITS + 17 + 7) / 8) * 8;

    cgcs_pkg::cmd_t    cmd;
    cgcs_pkg::status_t status;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [16:0] gain_now;

    cgcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cgcs_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .sample_in  ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .level_in   (s_tdata[SAMPLE_BITS+23:SAMPLE_BITS]),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .sample_out (sample_out),
        .gain_now   (gain_now)
    );

    assign m_tdata = OW'({gain_now, sample_out});

endmodule

### design/cgcs_ctrl.sv
// ----------------------------------------------------------------------------
// cgcs_ctrl
// sequencer that walks the datapath through log, divide, exp, smooth, output
// ----------------------------------------------------------------------------
module cgcs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cgcs_pkg::status_t  status,
    output cgcs_pkg::cmd_t     cmd
);

    cgcs_pkg::state_t state_reg;
    cgcs_pkg::state_t state_next;
    logic [4:0]       cnt_reg;
    logic [4:0]       cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cgcs_pkg::ST_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = 5'd0;
        cmd.op     = cgcs_pkg::OP_NOP;
        cmd.cnt    = cnt_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            cgcs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = cgcs_pkg::OP_LOAD;
                    state_next = cgcs_pkg::ST_CHECK;
                end
            end
            cgcs_pkg::ST_CHECK:
            begin
                if (status.above)
                begin
                    cmd.op     = cgcs_pkg::OP_LOG_INIT_L;
                    state_next = cgcs_pkg::ST_LOG_L;
                end
                else
                begin
                    state_next = cgcs_pkg::ST_SMOOTH;
                end
            end
            cgcs_pkg::ST_LOG_L:
            begin
                cmd.op = cgcs_pkg::OP_LOG_STEP;
                if (cnt_reg == 5'(cgcs_pkg::LOG_STEPS - 1))
                    state_next = cgcs_pkg::ST_LOG_T_INIT;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            cgcs_pkg::ST_LOG_T_INIT:
            begin
                cmd.op     = cgcs_pkg::OP_LOG_INIT_T;
                state_next = cgcs_pkg::ST_LOG_T;
            end
            cgcs_pkg::ST_LOG_T:
            begin
                cmd.op = cgcs_pkg::OP_LOG_STEP;
                if (cnt_reg == 5'(cgcs_pkg::LOG_STEPS - 1))
                    state_next = cgcs_pkg::ST_DIV_INIT;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            cgcs_pkg::ST_DIV_INIT:
            begin
                cmd.op     = cgcs_pkg::OP_DIV_INIT;
                state_next = cgcs_pkg::ST_DIV;
            end
            cgcs_pkg::ST_DIV:
            begin
                cmd.op = cgcs_pkg::OP_DIV_STEP;
                if (cnt_reg == 5'(cgcs_pkg::DIV_STEPS - 1))
                    state_next = cgcs_pkg::ST_MUL_P;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            cgcs_pkg::ST_MUL_P:
            begin
                cmd.op     = cgcs_pkg::OP_MUL_P;
                state_next = cgcs_pkg::ST_EXP_A;
            end
            cgcs_pkg::ST_EXP_A:
            begin
                cmd.op     = cgcs_pkg::OP_EXP_A;
                cnt_next   = cnt_reg;
                state_next = cgcs_pkg::ST_EXP_B;
            end
            cgcs_pkg::ST_EXP_B:
            begin
                cmd.op = cgcs_pkg::OP_EXP_B;
                if (cnt_reg == 5'(cgcs_pkg::EXP_STEPS - 1))
                    state_next = cgcs_pkg::ST_TARGET;
                else
                begin
                    cnt_next   = cnt_reg + 5'd1;
                    state_next = cgcs_pkg::ST_EXP_A;
                end
            end
            cgcs_pkg::ST_TARGET:
            begin
                cmd.op     = cgcs_pkg::OP_TARGET;
                state_next = cgcs_pkg::ST_SMOOTH;
            end
            cgcs_pkg::ST_SMOOTH:
            begin
                cmd.op     = cgcs_pkg::OP_SMOOTH;
                state_next = cgcs_pkg::ST_OUT_T;
            end
            cgcs_pkg::ST_OUT_T:
            begin
                cmd.op     = cgcs_pkg::OP_OUT_T;
                state_next = cgcs_pkg::ST_OUT_U;
            end
            cgcs_pkg::ST_OUT_U:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.op     = cgcs_pkg::OP_OUT_U;
                    state_next = cgcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cgcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/cgcs_dp.sv
// ----------------------------------------------------------------------------
// cgcs_dp
// datapath: config registers, log2, divider, exp2, smoother, output multiply
// ----------------------------------------------------------------------------
module cgcs_dp #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_addr,
    input  logic [23:0]                   cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [23:0]                   level_in,
    input  cgcs_pkg::cmd_t                cmd,
    output cgcs_pkg::status_t             status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic [16:0]                   gain_now
);

    localparam int TW = SAMPLE_BITS + 1;
    localparam int UW = SAMPLE_BITS + 6;
    localparam cgcs_pkg::exp_tbl_t EXP_TBL = cgcs_pkg::build_exp_tbl();

    // configuration
    logic [23:0] thr_cfg_reg;
    logic [12:0] ratio_cfg_reg;
    logic [15:0] attack_reg;
    logic [15:0] release_reg;
    logic [23:0] makeup_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_cfg_reg   <= 24'd4194304;
            ratio_cfg_reg <= 13'd256;
            attack_reg    <= 16'd0;
            release_reg   <= 16'd0;
            makeup_reg    <= 24'd1048576;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cgcs_pkg::CFG_THRESHOLD: thr_cfg_reg   <= cfg_wdata;
                cgcs_pkg::CFG_RATIO:     ratio_cfg_reg <= cfg_wdata[12:0];
                cgcs_pkg::CFG_ATTACK:    attack_reg    <= cfg_wdata[15:0];
                cgcs_pkg::CFG_RELEASE:   release_reg   <= cfg_wdata[15:0];
                cgcs_pkg::CFG_MAKEUP:    makeup_reg    <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    // working registers
    logic signed [SAMPLE_BITS-1:0] s_reg;
    logic [23:0] lvl_reg;
    logic [23:0] thr_reg;
    logic [12:0] rat_reg;
    logic [23:0] m_reg;
    logic [4:0]  msb_reg;
    logic [15:0] frac_reg;
    logic [20:0] ll_reg;
    logic [20:0] d_reg;
    logic [12:0] rem_reg;
    logic [16:0] q_reg;
    logic [20:0] p_reg;
    logic [30:0] acc_reg;
    logic [45:0] plo_reg;
    logic [16:0] target_reg;
    logic [16:0] gain_reg;
    logic signed [TW-1:0] t_reg;
    logic        out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic [16:0] gain_out_reg;

    // log2 normalisation
    logic [23:0] lx;
    logic [4:0]  lmsb;
    logic [23:0] lnorm;
    logic [47:0] sq;
    logic [24:0] sq_sh;
    logic [20:0] lt;
    // divider
    logic [13:0] r2;
    // exp and smoothing
    logic [29:0] tbl_e;
    logic [4:0]  tidx;
    logic [3:0]  pbit;
    logic [16:0] ne;
    logic [37:0] dp_prod;
    logic [60:0] hi_sum;
    logic [5:0]  shamt;
    logic [30:0] acc_sh;
    logic [16:0] gdiff;
    logic [16:0] one_m_c;
    logic [33:0] sprod;
    logic [16:0] gain_new;
    // output multiplies
    logic signed [SAMPLE_BITS+17:0] tmul;
    logic signed [SAMPLE_BITS+25:0] umul;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] umax;
    logic signed [UW-1:0] umin;
    logic signed [SAMPLE_BITS-1:0] usat;
    logic write_out;

    always_comb
    begin
        lx   = (cmd.op == cgcs_pkg::OP_LOG_INIT_T) ? thr_reg : lvl_reg;
        lmsb = 5'd0;
        for (int i = 0; i < 24; i++)
        begin
            if (lx[i])
                lmsb = 5'(i);
        end
        lnorm = lx << (5'd23 - lmsb);
        sq    = 48'(m_reg) * 48'(m_reg);
        sq_sh = sq[47:23];
        lt    = {msb_reg, frac_reg};
        r2    = {rem_reg, (cmd.cnt == 5'd0)};
        tidx  = cmd.cnt + 5'd1;
        tbl_e = EXP_TBL[tidx];
        pbit  = 4'hF - cmd.cnt[3:0];
        ne    = cgcs_pkg::UNITY_GAIN - q_reg;
        dp_prod = 38'(d_reg) * 38'(ne);
        hi_sum  = ((61'(acc_reg) * 61'(tbl_e[29:15])) << 15) + 61'(plo_reg);
        shamt   = 6'd14 + 6'(p_reg[20:16]);
        acc_sh  = acc_reg >> shamt;
        if (target_reg < gain_reg)
        begin
            gdiff   = gain_reg - target_reg;
            one_m_c = cgcs_pkg::UNITY_GAIN - 17'(attack_reg);
        end
        else
        begin
            gdiff   = target_reg - gain_reg;
            one_m_c = cgcs_pkg::UNITY_GAIN - 17'(release_reg);
        end
        sprod = 34'(gdiff) * 34'(one_m_c);
        if (target_reg < gain_reg)
            gain_new = gain_reg - sprod[32:16];
        else
            gain_new = gain_reg + sprod[32:16];
        tmul = s_reg * $signed({1'b0, gain_reg});
        umul = t_reg * $signed({1'b0, makeup_reg});
        u    = umul[SAMPLE_BITS+25:20];
        umax = {{7{1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
        umin = {{7{1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
        if (u > umax)
            usat = umax[SAMPLE_BITS-1:0];
        else if (u < umin)
            usat = umin[SAMPLE_BITS-1:0];
        else
            usat = u[SAMPLE_BITS-1:0];
    end

    assign write_out = (cmd.op == cgcs_pkg::OP_OUT_U);

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            cgcs_pkg::OP_LOAD:
            begin
                s_reg      <= sample_in;
                lvl_reg    <= level_in;
                thr_reg    <= (thr_cfg_reg == 24'd0) ? 24'd1 : thr_cfg_reg;
                target_reg <= cgcs_pkg::UNITY_GAIN;
                if (ratio_cfg_reg < 13'd256)
                    rat_reg <= 13'd256;
                else if (ratio_cfg_reg > 13'd5120)
                    rat_reg <= 13'd5120;
                else
                    rat_reg <= ratio_cfg_reg;
            end
            cgcs_pkg::OP_LOG_INIT_L:
            begin
                m_reg    <= lnorm;
                msb_reg  <= lmsb;
                frac_reg <= 16'd0;
            end
            cgcs_pkg::OP_LOG_INIT_T:
            begin
                ll_reg   <= {msb_reg, frac_reg};
                m_reg    <= lnorm;
                msb_reg  <= lmsb;
                frac_reg <= 16'd0;
            end
            cgcs_pkg::OP_LOG_STEP:
            begin
                // square, and pull out one fraction bit, set when the square reaches two
                m_reg    <= sq_sh[24] ? sq_sh[24:1] : sq_sh[23:0];
                frac_reg <= {frac_reg[14:0], sq_sh[24]};
            end
            cgcs_pkg::OP_DIV_INIT:
            begin
                d_reg   <= (ll_reg > lt) ? (ll_reg - lt) : 21'd0;
                rem_reg <= 13'd0;
                q_reg   <= 17'd0;
            end
            cgcs_pkg::OP_DIV_STEP:
            begin
                if (r2 >= 14'(rat_reg))
                begin
                    rem_reg <= 13'(r2 - 14'(rat_reg));
                    q_reg   <= {q_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_reg <= r2[12:0];
                    q_reg   <= {q_reg[15:0], 1'b0};
                end
            end
            cgcs_pkg::OP_MUL_P:
            begin
                p_reg   <= dp_prod[36:16];
                acc_reg <= 31'h40000000;
            end
            cgcs_pkg::OP_EXP_A:
            begin
                plo_reg <= 46'(acc_reg) * 46'(tbl_e[14:0]);
            end
            cgcs_pkg::OP_EXP_B:
            begin
                if (p_reg[pbit])
                    acc_reg <= hi_sum[60:30];
            end
            cgcs_pkg::OP_TARGET:
            begin
                target_reg <= acc_sh[16:0];
            end
            cgcs_pkg::OP_OUT_T:
            begin
                t_reg <= tmul[SAMPLE_BITS+16:16];
            end
            cgcs_pkg::OP_OUT_U:
            begin
                sample_out_reg <= usat;
                gain_out_reg   <= gain_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= cgcs_pkg::UNITY_GAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == cgcs_pkg::OP_SMOOTH)
                gain_reg <= gain_new;
            if (write_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.above    = (lvl_reg > thr_reg);
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = sample_out_reg;
    assign gain_now        = gain_out_reg;

endmodule

### design/cgcs_chk.sv
// ----------------------------------------------------------------------------
// cgcs_chk
// port-level checks for the compressor gain computer/smoother
// ----------------------------------------------------------------------------
module cgcs_chk #(
    parameter int SAMPLE_BITS = 24
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [((SAMPLE_BITS+17+7)/8)*8-1:0] m_tdata
);

    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // gain never exceeds unity
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[SAMPLE_BITS+16:SAMPLE_BITS] <= 17'h10000)
        else $error("gain above unity");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // no result is raised right after an input transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised right after input transfer");

endmodule

bind compressor_gain_computer_smoother_top cgcs_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cgcs_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
